>>> sv/bltp_pkg.sv
// Shared constants for the bitmap line and triangle plotter.
// Used by bltp_ram (through its parameters) and bitmap_line_triangle_plotter.
`default_nettype none
package bltp_pkg;

  localparam int GRID    = 64;                 // rows and columns kept in the bitmap
  localparam int COORD_W = 6;                  // width of a row or column coordinate
  localparam int ROW_W   = 64;                 // bits in one bitmap row
  localparam int ROW_AW  = $clog2(GRID);       // bitmap row address width
  localparam int MODE_W  = 3;
  localparam int SIZE_W  = 7;

  localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(64);
  localparam logic [SIZE_W-1:0] SIZE_MAX   = SIZE_W'(64);

  localparam logic [ROW_W-1:0] ALL_ONES = {ROW_W{1'b1}};
  // columns that exist in the grid
  localparam logic [ROW_W-1:0] COL_MASK = ALL_ONES >> (ROW_W - GRID);
  // first row index beyond the grid, one bit wider than a coordinate
  localparam logic [COORD_W:0] GRID_LIM = (COORD_W + 1)'(GRID);

  localparam logic [MODE_W-1:0] MODE_CLEAR = 3'd0;
  localparam logic [MODE_W-1:0] MODE_POINT = 3'd1;
  localparam logic [MODE_W-1:0] MODE_LINE  = 3'd2;
  localparam logic [MODE_W-1:0] MODE_TRI   = 3'd3;
  localparam logic [MODE_W-1:0] MODE_READ  = 3'd4;

  localparam logic [1:0] SEG_AB = 2'd0;
  localparam logic [1:0] SEG_BC = 2'd1;
  localparam logic [1:0] SEG_CA = 2'd2;

endpackage
`default_nettype wire

>>> sv/bltp_ram.sv
// Generic single-clock RAM: one write port, one read port, registered read data.
// No dependencies; a read of the address written at the same edge returns the old word.
`default_nettype none
module bltp_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

>>> sv/bitmap_line_triangle_plotter.sv
// Top level of the bitmap line and triangle plotter: command sequencer, line stepper,
// small floor divider and row read-modify-write pipeline. Uses bltp_pkg and bltp_ram.
//
//   channel | ports                                   | beat taken when
//   --------+-----------------------------------------+------------------------
//   command | start, busy, in_mode, in_ax .. in_cy    | start & !busy
//   result  | out_valid, out_row_bits, out_is_read    | out_valid (one cycle)
//   config  | cfg_we, cfg_wdata (active_size)         | cfg_we
//
// Every command gives one result beat, in the first cycle with busy low after it is taken.
// Clear passes through S_CLR and read row through S_READ1 and S_READ2; an unknown mode is
// answered from idle. Point and line: a setup state per segment, plus for a non-vertical
// segment the divider, a fixup and one step per row (up to 64 rows; a triangle's three row
// spans add to at most 126). The bitmap RAM port sets the stepping rate of one row per cycle.
// Row valid flops make reset and clear immediate; no clearing pass. The receiver cannot stall.
`default_nettype none
module bitmap_line_triangle_plotter (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [bltp_pkg::MODE_W-1:0]   in_mode,
  input  logic [bltp_pkg::COORD_W-1:0]  in_ax,
  input  logic [bltp_pkg::COORD_W-1:0]  in_ay,
  input  logic [bltp_pkg::COORD_W-1:0]  in_bx,
  input  logic [bltp_pkg::COORD_W-1:0]  in_by,
  input  logic [bltp_pkg::COORD_W-1:0]  in_cx,
  input  logic [bltp_pkg::COORD_W-1:0]  in_cy,
  input  logic                          cfg_we,
  input  logic [bltp_pkg::SIZE_W-1:0]   cfg_wdata,
  output logic                          out_valid,
  output logic [bltp_pkg::ROW_W-1:0]    out_row_bits,
  output logic                          out_is_read
);
  import bltp_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_CLR   = 4'd1;
  localparam logic [3:0] S_SETUP = 4'd2;
  localparam logic [3:0] S_DIV   = 4'd3;
  localparam logic [3:0] S_FIX   = 4'd4;
  localparam logic [3:0] S_STEP  = 4'd5;
  localparam logic [3:0] S_READ1 = 4'd6;
  localparam logic [3:0] S_READ2 = 4'd7;

  logic [3:0] state_r, state_nxt;

  // command fields
  logic [MODE_W-1:0]  mode_r;
  logic [COORD_W-1:0] ax_r, ay_r, bx_r, by_r, cx_r, cy_r;
  logic [1:0]         seg_r, seg_nxt;
  logic [SIZE_W-1:0]  size_r;

  // segment stepper
  logic [COORD_W-1:0] i_r, i_nxt, end_r, end_nxt, col_r, col_nxt;
  logic [COORD_W-1:0] den_r, den_nxt, dvd_r, dvd_nxt;
  logic [COORD_W-1:0] rem_r, rem_nxt, quo_r, quo_nxt;
  logic [COORD_W-1:0] q_r, q_nxt, r_r, r_nxt, acc_r, acc_nxt;
  logic               neg_r, neg_nxt;
  logic [2:0]         cnt_r, cnt_nxt;

  // row write pipeline
  logic               iss_valid;
  logic [COORD_W-1:0] iss_row;
  logic [ROW_W-1:0]   iss_mask;
  logic               p2_valid_r;
  logic [COORD_W-1:0] p2_row_r;
  logic [ROW_W-1:0]   p2_mask_r;
  logic               wl_valid_r;
  logic [COORD_W-1:0] wl_row_r;
  logic [ROW_W-1:0]   wl_data_r;
  logic [GRID-1:0]    row_ok_r, row_ok_nxt;

  logic               ram_we;
  logic [ROW_AW-1:0]  ram_raddr;
  logic [ROW_W-1:0]   ram_rdata, ram_wdata, base_row;

  logic               out_valid_r, out_valid_nxt, out_is_read_r, out_is_read_nxt;
  logic [ROW_W-1:0]   out_bits_r, out_bits_nxt;

  // segment endpoints
  logic [COORD_W-1:0] x1, y1, x2, y2, sx, sy, ex, ey, lo_c, hi_c;
  logic               seg_last;
  logic [COORD_W:0]   dy, rem_sh, step_sum;
  logic               step_carry;
  logic [SIZE_W-1:0]  size_eff;
  logic [ROW_W-1:0]   size_mask, read_row;

  bltp_ram #(.WIDTH(ROW_W), .DEPTH(GRID)) u_rows (
    .clk   (clk),
    .we    (ram_we),
    .waddr (p2_row_r[ROW_AW-1:0]),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    unique case (seg_r)
      SEG_BC: begin
        x1 = bx_r; y1 = by_r; x2 = cx_r; y2 = cy_r;
      end
      SEG_CA: begin
        x1 = cx_r; y1 = cy_r; x2 = ax_r; y2 = ay_r;
      end
      default: begin
        x1 = ax_r; y1 = ay_r;
        x2 = (mode_r == MODE_POINT) ? ax_r : bx_r;
        y2 = (mode_r == MODE_POINT) ? ay_r : by_r;
      end
    endcase
    seg_last = (mode_r != MODE_TRI) || (seg_r == SEG_CA);
    // step from the lower row upward
    sx = (x1 < x2) ? x1 : x2;
    sy = (x1 < x2) ? y1 : y2;
    ex = (x1 < x2) ? x2 : x1;
    ey = (x1 < x2) ? y2 : y1;
    dy = {1'b0, ey} - {1'b0, sy};
    lo_c = (y1 < y2) ? y1 : y2;
    hi_c = (y1 < y2) ? y2 : y1;
    rem_sh = {rem_r, dvd_r[COORD_W-1]};
    step_sum = {1'b0, acc_r} + {1'b0, r_r};
    step_carry = step_sum >= {1'b0, den_r};
  end

  // forwarding covers a row written at the same edge its read was taken
  always_comb begin
    if (!row_ok_r[p2_row_r[ROW_AW-1:0]]) begin
      base_row = '0;
    end else if (wl_valid_r && wl_row_r == p2_row_r) begin
      base_row = wl_data_r;
    end else begin
      base_row = ram_rdata;
    end
    ram_wdata = base_row | p2_mask_r;
    ram_we    = p2_valid_r && ({1'b0, p2_row_r} < GRID_LIM);
    ram_raddr = (state_r == S_READ1) ? ax_r[ROW_AW-1:0] : iss_row[ROW_AW-1:0];
  end

  always_comb begin
    size_eff  = (size_r > SIZE_MAX) ? SIZE_MAX : size_r;
    size_mask = (size_eff >= SIZE_MAX) ? ALL_ONES : ~(ALL_ONES << size_eff);
    read_row  = '0;
    if ({1'b0, ax_r} < GRID_LIM && SIZE_W'(ax_r) < size_eff
        && row_ok_r[ax_r[ROW_AW-1:0]]) begin
      read_row = ram_rdata & size_mask;
    end
  end

  always_comb begin
    state_nxt       = state_r;
    seg_nxt         = seg_r;
    i_nxt           = i_r;
    end_nxt         = end_r;
    col_nxt         = col_r;
    den_nxt         = den_r;
    dvd_nxt         = dvd_r;
    rem_nxt         = rem_r;
    quo_nxt         = quo_r;
    q_nxt           = q_r;
    r_nxt           = r_r;
    acc_nxt         = acc_r;
    neg_nxt         = neg_r;
    cnt_nxt         = cnt_r;
    iss_valid       = 1'b0;
    iss_row         = i_r;
    iss_mask        = '0;
    out_valid_nxt   = 1'b0;
    out_is_read_nxt = 1'b0;
    out_bits_nxt    = '0;
    row_ok_nxt      = row_ok_r;
    if (ram_we) begin
      row_ok_nxt[p2_row_r[ROW_AW-1:0]] = 1'b1;
    end
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          seg_nxt = SEG_AB;
          unique case (in_mode)
            MODE_CLEAR: state_nxt = S_CLR;
            MODE_POINT, MODE_LINE, MODE_TRI: state_nxt = S_SETUP;
            MODE_READ: state_nxt = S_READ1;
            default: out_valid_nxt = 1'b1;
          endcase
        end
      end
      S_CLR: begin
        row_ok_nxt    = '0;
        out_valid_nxt = 1'b1;
        state_nxt     = S_IDLE;
      end
      S_SETUP: begin
        if (x1 == x2) begin
          // vertical: one row, a run of columns
          iss_valid = 1'b1;
          iss_row   = x1;
          iss_mask  = (ALL_ONES >> (COORD_W'(ROW_W - 1) - hi_c)) & (ALL_ONES << lo_c) & COL_MASK;
          if (seg_last) begin
            out_valid_nxt = 1'b1;
            state_nxt     = S_IDLE;
          end else begin
            seg_nxt = seg_r + 2'd1;
          end
        end else begin
          i_nxt     = sx;
          end_nxt   = ex;
          col_nxt   = sy;
          den_nxt   = ex - sx;
          neg_nxt   = dy[COORD_W];
          dvd_nxt   = dy[COORD_W] ? COORD_W'(-dy) : dy[COORD_W-1:0];
          rem_nxt   = '0;
          quo_nxt   = '0;
          cnt_nxt   = '0;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        // restoring divide, one quotient bit per cycle
        if (rem_sh >= {1'b0, den_r}) begin
          rem_nxt = COORD_W'(rem_sh - {1'b0, den_r});
          quo_nxt = {quo_r[COORD_W-2:0], 1'b1};
        end else begin
          rem_nxt = rem_sh[COORD_W-1:0];
          quo_nxt = {quo_r[COORD_W-2:0], 1'b0};
        end
        dvd_nxt = {dvd_r[COORD_W-2:0], 1'b0};
        cnt_nxt = cnt_r + 3'd1;
        if (cnt_r == 3'(COORD_W - 1)) begin
          state_nxt = S_FIX;
        end
      end
      S_FIX: begin
        // turn truncation of |dy|/den into floor of dy/den, remainder in [0, den)
        if (neg_r && rem_r != '0) begin
          q_nxt = ~quo_r;
          r_nxt = den_r - rem_r;
        end else if (neg_r) begin
          q_nxt = -quo_r;
          r_nxt = '0;
        end else begin
          q_nxt = quo_r;
          r_nxt = rem_r;
        end
        acc_nxt   = '0;
        state_nxt = S_STEP;
      end
      S_STEP: begin
        iss_valid = 1'b1;
        iss_row   = i_r;
        iss_mask  = (ROW_W'(1) << col_r) & COL_MASK;
        acc_nxt   = step_carry ? COORD_W'(step_sum - {1'b0, den_r}) : step_sum[COORD_W-1:0];
        col_nxt   = col_r + q_r + COORD_W'(step_carry);
        i_nxt     = i_r + COORD_W'(1);
        if (i_r == end_r) begin
          if (seg_last) begin
            out_valid_nxt = 1'b1;
            state_nxt     = S_IDLE;
          end else begin
            seg_nxt   = seg_r + 2'd1;
            state_nxt = S_SETUP;
          end
        end
      end
      S_READ1: begin
        state_nxt = S_READ2;
      end
      S_READ2: begin
        out_valid_nxt   = 1'b1;
        out_is_read_nxt = 1'b1;
        out_bits_nxt    = read_row;
        state_nxt       = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      size_r      <= SIZE_RESET;
      row_ok_r    <= '0;
      p2_valid_r  <= 1'b0;
      wl_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      row_ok_r    <= row_ok_nxt;
      p2_valid_r  <= iss_valid;
      wl_valid_r  <= ram_we;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        size_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && start) begin
      mode_r <= in_mode;
      ax_r   <= in_ax;
      ay_r   <= in_ay;
      bx_r   <= in_bx;
      by_r   <= in_by;
      cx_r   <= in_cx;
      cy_r   <= in_cy;
    end
    seg_r         <= seg_nxt;
    i_r           <= i_nxt;
    end_r         <= end_nxt;
    col_r         <= col_nxt;
    den_r         <= den_nxt;
    dvd_r         <= dvd_nxt;
    rem_r         <= rem_nxt;
    quo_r         <= quo_nxt;
    q_r           <= q_nxt;
    r_r           <= r_nxt;
    acc_r         <= acc_nxt;
    neg_r         <= neg_nxt;
    cnt_r         <= cnt_nxt;
    p2_row_r      <= iss_row;
    p2_mask_r     <= iss_mask;
    wl_row_r      <= p2_row_r;
    wl_data_r     <= ram_wdata;
    out_bits_r    <= out_bits_nxt;
    out_is_read_r <= out_is_read_nxt;
  end

  assign busy         = (state_r != S_IDLE);
  assign out_valid    = out_valid_r;
  assign out_row_bits = out_bits_r;
  assign out_is_read  = out_is_read_r;

endmodule
`default_nettype wire
